// ----- hw/rtl/packbits_bitmap_decoder_macros.svh -----
// Assertion macros shared by the PackBits bitmap decoder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PACKBITS_BITMAP_DECODER_MACROS_SVH
`define PACKBITS_BITMAP_DECODER_MACROS_SVH

// Check that prop holds on every clock edge outside reset.
`define PBD_ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that cons holds on the edge after ante.
`define PBD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pbd_pkg.sv -----
// Shared types and constants of the PackBits bitmap decoder.
// Used by pbd_core, pbd_out_buf and packbits_bitmap_decoder; no dependencies.
package pbd_pkg;

    localparam int IMAGE_WIDTH   = 576;
    localparam int IMAGE_HEIGHT  = 720;
    localparam int HEADER_BYTES  = 512;
    localparam int WRAPPER_BYTES = 128;

    localparam int PACKED_TOTAL  = (IMAGE_WIDTH / 8) * IMAGE_HEIGHT;

    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 16;
    localparam int LEN_W    = 8;
    localparam int STATUS_W = 2;

    // Position counter must hold the total itself and feed a 16-bit index.
    localparam int POS_W_RAW = $clog2(PACKED_TOTAL + 1);
    localparam int POS_W     = (POS_W_RAW > IDX_W) ? POS_W_RAW : IDX_W;

    localparam int HDR_MAX = HEADER_BYTES + WRAPPER_BYTES;
    localparam int HDR_W   = $clog2(HDR_MAX + 1);

    localparam logic [POS_W-1:0] TOTAL_POS = POS_W'(PACKED_TOTAL);
    localparam logic [HDR_W-1:0] HDR_BASE  = HDR_W'(HEADER_BYTES);
    localparam logic [HDR_W-1:0] HDR_WRAP  = HDR_W'(HDR_MAX);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;

    typedef struct packed {
        logic                pixel_valid;
        logic [BYTE_W-1:0]   pixel_byte;
        logic [IDX_W-1:0]    out_index;
        logic [LEN_W-1:0]    run_length;
        logic                finished;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

// ----- hw/rtl/pbd_core.sv -----
// Decoder state machine: header skip, PackBits flag parsing and run emission.
// Depends on pbd_pkg and packbits_bitmap_decoder_macros.svh.
`include "packbits_bitmap_decoder_macros.svh"

module pbd_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      take,
    input  logic [pbd_pkg::BYTE_W-1:0] in_byte,
    input  logic                      in_last,
    output logic                      res_vld,
    output pbd_pkg::res_t             res
);

    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_FLAG    = 3'd3;
    localparam logic [2:0] PH_LITERAL = 3'd4;
    localparam logic [2:0] PH_REPEAT  = 3'd5;
    localparam logic [2:0] PH_SKIP    = 3'd6;

    localparam logic [pbd_pkg::HDR_W-1:0] HDR_TWO = pbd_pkg::HDR_W'(2);

    logic [2:0]                      phase_reg, phase_next;
    logic [pbd_pkg::HDR_W-1:0]       hdr_pos_reg, hdr_pos_next;
    logic                            wrapped_reg, wrapped_next;
    logic [pbd_pkg::LEN_W-1:0]       lit_rem_reg, lit_rem_next;
    logic [pbd_pkg::LEN_W-1:0]       rep_len_reg, rep_len_next;
    logic [pbd_pkg::POS_W-1:0]       pos_reg, pos_next;

    logic [pbd_pkg::LEN_W-1:0]       emit_len;
    logic [pbd_pkg::POS_W-1:0]       pos_sum;
    logic                            emit_done;
    logic [pbd_pkg::POS_W-1:0]       room;
    logic [pbd_pkg::LEN_W-1:0]       raw_count;
    logic [pbd_pkg::LEN_W-1:0]       clip_count;
    logic [pbd_pkg::HDR_W-1:0]       hdr_inc;
    logic [pbd_pkg::HDR_W-1:0]       hdr_total;
    logic [pbd_pkg::HDR_W-1:0]       sec_total;
    logic [pbd_pkg::LEN_W-1:0]       lit_dec;
    logic                            clear;

    assign emit_len  = (phase_reg == PH_REPEAT) ? rep_len_reg : pbd_pkg::LEN_W'(1);
    assign pos_sum   = pos_reg + pbd_pkg::POS_W'(emit_len);
    assign emit_done = (pos_sum >= pbd_pkg::TOTAL_POS);

    assign room = (pbd_pkg::TOTAL_POS > pos_reg) ? (pbd_pkg::TOTAL_POS - pos_reg) : '0;

    // Literal flag gives flag+1 bytes, repeat flag gives 257-flag copies.
    assign raw_count = in_byte[7] ? pbd_pkg::LEN_W'(9'd257 - {1'b0, in_byte})
                                  : (in_byte + pbd_pkg::LEN_W'(1));
    assign clip_count = (pbd_pkg::POS_W'(raw_count) > room) ? room[pbd_pkg::LEN_W-1:0]
                                                             : raw_count;

    assign hdr_inc   = hdr_pos_reg + pbd_pkg::HDR_W'(1);
    assign hdr_total = wrapped_reg ? pbd_pkg::HDR_WRAP : pbd_pkg::HDR_BASE;
    assign sec_total = (in_byte != '0) ? pbd_pkg::HDR_WRAP : pbd_pkg::HDR_BASE;
    assign lit_dec   = (lit_rem_reg != '0) ? (lit_rem_reg - pbd_pkg::LEN_W'(1)) : '0;

    always_comb begin
        phase_next   = phase_reg;
        hdr_pos_next = hdr_pos_reg;
        wrapped_next = wrapped_reg;
        lit_rem_next = lit_rem_reg;
        rep_len_next = rep_len_reg;
        pos_next     = pos_reg;
        res_vld      = 1'b0;
        res          = '0;
        clear        = 1'b0;

        if (take) begin
            unique case (phase_reg) inside
                PH_FIRST: begin
                    if (in_last) begin
                        res_vld      = 1'b1;
                        res.finished = 1'b1;
                        res.status   = pbd_pkg::ST_TRUNC;
                        clear        = 1'b1;
                    end else if (in_byte != '0) begin
                        res_vld      = 1'b1;
                        res.finished = 1'b1;
                        res.status   = pbd_pkg::ST_INVALID;
                        phase_next   = PH_SKIP;
                    end else begin
                        hdr_pos_next = pbd_pkg::HDR_W'(1);
                        phase_next   = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    if (in_last) begin
                        res_vld      = 1'b1;
                        res.finished = 1'b1;
                        res.status   = pbd_pkg::ST_TRUNC;
                        clear        = 1'b1;
                    end else begin
                        wrapped_next = (in_byte != '0);
                        hdr_pos_next = HDR_TWO;
                        phase_next   = (HDR_TWO >= sec_total) ? PH_FLAG : PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (in_last) begin
                        res_vld      = 1'b1;
                        res.finished = 1'b1;
                        res.status   = pbd_pkg::ST_TRUNC;
                        clear        = 1'b1;
                    end else begin
                        hdr_pos_next = hdr_inc;
                        if (hdr_inc >= hdr_total) begin
                            phase_next = PH_FLAG;
                        end
                    end
                end
                PH_FLAG: begin
                    if (in_last) begin
                        res_vld      = 1'b1;
                        res.finished = 1'b1;
                        res.status   = pbd_pkg::ST_TRUNC;
                        clear        = 1'b1;
                    end else if (!in_byte[7]) begin
                        lit_rem_next = clip_count;
                        phase_next   = PH_LITERAL;
                    end else begin
                        rep_len_next = clip_count;
                        phase_next   = PH_REPEAT;
                    end
                end
                PH_LITERAL, PH_REPEAT: begin
                    if (phase_reg == PH_LITERAL) begin
                        lit_rem_next = lit_dec;
                        if (lit_dec == '0) begin
                            phase_next = PH_FLAG;
                        end
                    end else begin
                        phase_next = PH_FLAG;
                    end
                    res_vld  = 1'b1;
                    pos_next = pos_sum;
                    if (emit_done) begin
                        // Image complete: report the run together with success.
                        res.pixel_valid = 1'b1;
                        res.pixel_byte  = in_byte;
                        res.out_index   = pos_reg[pbd_pkg::IDX_W-1:0];
                        res.run_length  = emit_len;
                        res.finished    = 1'b1;
                        res.status      = pbd_pkg::ST_OK;
                        if (in_last) begin
                            clear = 1'b1;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end else if (in_last) begin
                        // Early end: drop the pixels, report truncation.
                        res.finished = 1'b1;
                        res.status   = pbd_pkg::ST_TRUNC;
                        clear        = 1'b1;
                    end else begin
                        res.pixel_valid = 1'b1;
                        res.pixel_byte  = in_byte;
                        res.out_index   = pos_reg[pbd_pkg::IDX_W-1:0];
                        res.run_length  = emit_len;
                    end
                end
                default: begin
                    if (in_last) begin
                        clear = 1'b1;
                    end
                end
            endcase

            if (clear) begin
                phase_next   = PH_FIRST;
                hdr_pos_next = '0;
                wrapped_next = 1'b0;
                lit_rem_next = '0;
                rep_len_next = '0;
                pos_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIRST;
            hdr_pos_reg <= '0;
            wrapped_reg <= 1'b0;
            lit_rem_reg <= '0;
            rep_len_reg <= '0;
            pos_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            hdr_pos_reg <= hdr_pos_next;
            wrapped_reg <= wrapped_next;
            lit_rem_reg <= lit_rem_next;
            rep_len_reg <= rep_len_next;
            pos_reg     <= pos_next;
        end
    end

    `PBD_ASSERT_ALWAYS(a_pos_in_image, aclk, aresetn,
        pos_reg <= pbd_pkg::TOTAL_POS, "position beyond image")
    `PBD_ASSERT_ALWAYS(a_literal_pending, aclk, aresetn,
        (phase_reg != PH_LITERAL) || (lit_rem_reg != '0), "literal phase with no bytes left")
    `PBD_ASSERT_ALWAYS(a_run_nonzero, aclk, aresetn,
        !(res_vld && res.pixel_valid) || (res.run_length != '0), "pixel run of zero length")
    `PBD_ASSERT_ALWAYS(a_ok_has_pixels, aclk, aresetn,
        !(res_vld && res.finished && (res.status == pbd_pkg::ST_OK)) || res.pixel_valid,
        "success without the completing run")
    `PBD_ASSERT_NEXT(a_done_skips, aclk, aresetn,
        take && res_vld && res.finished && !in_last, phase_reg == PH_SKIP,
        "finished file not skipping to marker")

endmodule

// ----- hw/rtl/pbd_out_buf.sv -----
// Two-entry result buffer: output register plus skid entry.
// Depends on pbd_pkg and packbits_bitmap_decoder_macros.svh.
`include "packbits_bitmap_decoder_macros.svh"

module pbd_out_buf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pbd_pkg::res_t push_data,
    output logic          full,
    output logic          out_vld,
    input  logic          out_rdy,
    output pbd_pkg::res_t out_data
);

    logic          main_vld_reg, main_vld_next;
    logic          skid_vld_reg, skid_vld_next;
    pbd_pkg::res_t main_reg, main_next;
    pbd_pkg::res_t skid_reg, skid_next;
    logic          pop;

    assign pop      = main_vld_reg && out_rdy;
    assign full     = main_vld_reg && skid_vld_reg;
    assign out_vld  = main_vld_reg;
    assign out_data = main_reg;

    always_comb begin
        main_vld_next = main_vld_reg;
        skid_vld_next = skid_vld_reg;
        main_next     = main_reg;
        skid_next     = skid_reg;
        if (pop || !main_vld_reg) begin
            if (skid_vld_reg) begin
                // Advance the skid entry, refill it with any new item.
                main_vld_next = 1'b1;
                main_next     = skid_reg;
                skid_vld_next = push;
                if (push) begin
                    skid_next = push_data;
                end
            end else begin
                main_vld_next = push;
                if (push) begin
                    main_next = push_data;
                end
            end
        end else if (push) begin
            skid_vld_next = 1'b1;
            skid_next     = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            main_vld_reg <= main_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `PBD_ASSERT_ALWAYS(a_skid_behind_main, aclk, aresetn, !skid_vld_reg || main_vld_reg, "skid entry without output entry")
    `PBD_ASSERT_ALWAYS(a_no_push_when_full, aclk, aresetn, !(push && full), "item pushed into full buffer")
    `PBD_ASSERT_NEXT(a_stall_keeps_item, aclk, aresetn, main_vld_reg && !out_rdy, main_vld_reg && (main_reg == $past(main_reg)), "stalled output item lost")

endmodule

// ----- hw/rtl/packbits_bitmap_decoder.sv -----
// PackBits bitmap decoder, top level. Takes one file byte per cycle and emits
// at most one pixel run or end report per byte. One byte is accepted every
// cycle while the result side keeps up; each byte is held in the input
// register until the result buffer has room, is decoded from there, and its
// result is written into the output buffer that drives the master side. The
// output register has a skid entry behind it that catches the result of a
// stalled cycle; while that entry is occupied the input is held, and a
// longer stall holds s_tready low once both entries and the input register are
// occupied. No clearing pass after reset.
// Depends on pbd_pkg, pbd_core and pbd_out_buf.
module packbits_bitmap_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] pixel_byte, [23:8] out_index, [31:24] run_length
    output logic [2:0]  m_tuser,   // [0] pixel_valid, [2:1] status
    output logic        m_tlast    // finished
);

    logic                       in_vld_reg, in_vld_next;
    logic [pbd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_last_reg;
    logic                       take;
    logic                       buf_full;
    logic                       res_vld;
    pbd_pkg::res_t              res;
    pbd_pkg::res_t              out_res;

    // Decode the held item whenever the result buffer has room.
    assign take     = in_vld_reg && !buf_full;
    assign s_tready = !in_vld_reg || take;

    assign in_vld_next = s_tready ? s_tvalid : in_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    pbd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .res_vld (res_vld),
        .res     (res)
    );

    pbd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_vld),
        .push_data (res),
        .full      (buf_full),
        .out_vld   (m_tvalid),
        .out_rdy   (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.run_length, out_res.out_index, out_res.pixel_byte};
    assign m_tuser = {out_res.status, out_res.pixel_valid};
    assign m_tlast = out_res.finished;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the PackBits bitmap decoder: streams bitmap files
// into the block and checks every result against a predictor of the decoder.
// Depends on pbd_pkg and packbits_bitmap_decoder.
module tb;

    localparam int IDLE_PCT    = 26;
    localparam int LONG_HOLD   = 60;
    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam int RANDOM_ITEMS = 2000;

    typedef enum logic [2:0] {
        WAIT_FIRST,
        WAIT_SECOND,
        IN_HEADER,
        AT_FLAG,
        IN_LITERAL,
        IN_REPEAT,
        SKIP_TO_END
    } dec_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    packbits_bitmap_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    dec_phase_t  dec_phase;
    int unsigned hdr_pos;
    logic        wrapped;
    int unsigned lit_left;
    int unsigned rep_len;
    int unsigned out_pos;

    logic [8:0]    file_bytes[$];   // {last_byte, data_byte}
    pbd_pkg::res_t run_reports[$];

    int  bytes_queued = 0;
    int  bytes_sent = 0;
    int  reports_seen = 0;
    int  errors = 0;
    int  cycle_count = 0;
    int  stuck_cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  byte_taken = 1'b0;
    logic no_gaps;

    assign no_gaps = (cycle_count % 2048) >= 1536;

    function automatic void clear_decoder();
        dec_phase = WAIT_FIRST;
        hdr_pos   = 0;
        wrapped   = 1'b0;
        lit_left  = 0;
        rep_len   = 0;
        out_pos   = 0;
    endfunction

    function automatic int unsigned header_len();
        return pbd_pkg::HEADER_BYTES + (wrapped ? pbd_pkg::WRAPPER_BYTES : 0);
    endfunction

    function automatic string res_str(pbd_pkg::res_t r);
        return $sformatf("valid=%0b byte=%02h index=%0d length=%0d finished=%0b status=%0d",
                         r.pixel_valid, r.pixel_byte, r.out_index, r.run_length,
                         r.finished, r.status);
    endfunction

    function automatic void report_truncated();
        pbd_pkg::res_t r;
        r = '0;
        r.finished = 1'b1;
        r.status = pbd_pkg::ST_TRUNC;
        run_reports.push_back(r);
        clear_decoder();
    endfunction

    function automatic void put_run(logic [7:0] data, int unsigned len, logic last);
        pbd_pkg::res_t r;
        int unsigned at;
        r = '0;
        at = out_pos;
        out_pos += len;
        if (out_pos >= pbd_pkg::PACKED_TOTAL) begin
            r.pixel_valid = 1'b1;
            r.pixel_byte = data;
            r.out_index = at[15:0];
            r.run_length = len[7:0];
            r.finished = 1'b1;
            r.status = pbd_pkg::ST_OK;
            run_reports.push_back(r);
            if (last) clear_decoder();
            else dec_phase = SKIP_TO_END;
        end else if (last) begin
            // an early end drops the pixels of the marked byte
            report_truncated();
        end else begin
            r.pixel_valid = 1'b1;
            r.pixel_byte = data;
            r.out_index = at[15:0];
            r.run_length = len[7:0];
            run_reports.push_back(r);
        end
    endfunction

    function automatic void decode_byte(logic [7:0] data, logic last);
        pbd_pkg::res_t r;
        int unsigned count;
        int unsigned room;
        case (dec_phase)
            WAIT_FIRST: begin
                if (last) begin
                    report_truncated();
                end else if (data != 8'h00) begin
                    r = '0;
                    r.finished = 1'b1;
                    r.status = pbd_pkg::ST_INVALID;
                    run_reports.push_back(r);
                    dec_phase = SKIP_TO_END;
                end else begin
                    hdr_pos = 1;
                    dec_phase = WAIT_SECOND;
                end
            end
            WAIT_SECOND: begin
                if (last) begin
                    report_truncated();
                end else begin
                    wrapped = data != 8'h00;
                    hdr_pos = 2;
                    dec_phase = (hdr_pos >= header_len()) ? AT_FLAG : IN_HEADER;
                end
            end
            IN_HEADER: begin
                if (last) begin
                    report_truncated();
                end else begin
                    hdr_pos++;
                    if (hdr_pos >= header_len()) dec_phase = AT_FLAG;
                end
            end
            AT_FLAG: begin
                if (last) begin
                    report_truncated();
                end else begin
                    count = (data < 128) ? data + 1 : 257 - data;
                    room = (pbd_pkg::PACKED_TOTAL > out_pos) ?
                           pbd_pkg::PACKED_TOTAL - out_pos : 0;
                    if (count > room) count = room;
                    if (data < 128) begin
                        lit_left = count;
                        dec_phase = IN_LITERAL;
                    end else begin
                        rep_len = count;
                        dec_phase = IN_REPEAT;
                    end
                end
            end
            IN_LITERAL: begin
                if (lit_left > 0) lit_left--;
                if (lit_left == 0) dec_phase = AT_FLAG;
                put_run(data, 1, last);
            end
            IN_REPEAT: begin
                dec_phase = AT_FLAG;
                put_run(data, rep_len, last);
            end
            default: begin
                if (last) clear_decoder();
            end
        endcase
    endfunction

    // input side: hold the item until taken, then offer the next one or idle
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || byte_taken)) begin
            if (file_bytes.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
                {s_tlast, s_tdata} <= file_bytes.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: random stalls, plus one long hold-off once decoding runs
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && reports_seen >= 40) begin
            m_tready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        pbd_pkg::res_t got;
        pbd_pkg::res_t want;
        cycle_count++;
        if (aresetn) begin
            byte_taken <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
            else stuck_cycles++;
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (m_tvalid && m_tready) begin
                got.pixel_valid = m_tuser[0];
                got.pixel_byte  = m_tdata[7:0];
                got.out_index   = m_tdata[23:8];
                got.run_length  = m_tdata[31:24];
                got.finished    = m_tlast;
                got.status      = m_tuser[2:1];
                reports_seen++;
                if (run_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %s",
                             $time, res_str(got));
                end else begin
                    want = run_reports.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch, expected %s, got %s",
                                 $time, res_str(want), res_str(got));
                    end
                end
            end
        end
    end

    task automatic push_item(input logic [7:0] data, input logic last);
        file_bytes.push_back({last, data});
        bytes_queued++;
    endtask

    task automatic wait_for_drain();
        while (bytes_sent != bytes_queued || run_reports.size() != 0) @(posedge aclk);
    endtask

    // Build one file: header, then PackBits runs. A whole image ends either on
    // the completing byte or after a few ignored bytes; otherwise the marker
    // lands body_len bytes past the header, wherever that falls.
    task automatic queue_file(input bit fill_image, input int unsigned body_len);
        logic [7:0]  fb[$];
        logic [7:0]  flag;
        int unsigned hdr_total;
        int unsigned pos;
        int unsigned runs;
        int unsigned k;
        fb.push_back(8'h00);
        fb.push_back($urandom_range(1) ? 8'($urandom_range(1, 255)) : 8'h00);
        hdr_total = pbd_pkg::HEADER_BYTES + ((fb[1] != 8'h00) ? pbd_pkg::WRAPPER_BYTES : 0);
        while (fb.size() < hdr_total) fb.push_back(8'($urandom));
        pos = 0;
        runs = 0;
        while (fill_image ? pos < pbd_pkg::PACKED_TOTAL : fb.size() < hdr_total + body_len) begin
            if (fill_image && runs < 4) begin
                // longest literal, longest repeat, shortest repeat, single literal
                case (runs)
                    0: flag = 8'h7F;
                    1: flag = 8'h80;
                    2: flag = 8'hFF;
                    default: flag = 8'h00;
                endcase
            end else if ($urandom_range(99) < (fill_image ? 85 : 50)) begin
                flag = fill_image ? 8'($urandom_range(128, 140)) : 8'($urandom_range(128, 255));
            end else begin
                flag = fill_image ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 127));
            end
            fb.push_back(flag);
            if (flag[7]) begin
                fb.push_back(8'($urandom));
                pos += 257 - flag;
            end else begin
                for (k = 0; k <= flag && pos < pbd_pkg::PACKED_TOTAL; k++) begin
                    fb.push_back(8'($urandom));
                    pos++;
                end
            end
            runs++;
        end
        if (!fill_image) begin
            while (fb.size() > hdr_total + body_len) void'(fb.pop_back());
        end else if ($urandom_range(1)) begin
            k = $urandom_range(1, 6);
            repeat (k) fb.push_back(8'($urandom));
        end
        for (k = 0; k < fb.size(); k++) push_item(fb[k], k == fb.size() - 1);
    endtask

    // short broken file: bad or good first byte, a few random bytes, marker
    task automatic queue_noise();
        int unsigned n;
        int unsigned k;
        n = $urandom_range(0, 12);
        push_item($urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 255)), n == 0);
        for (k = 1; k <= n; k++) push_item(8'($urandom), k == n);
    endtask

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int random_start;
        clear_decoder();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // one-byte files
        push_item(8'h00, 1'b1);
        push_item(8'hFF, 1'b1);
        // invalid first byte, ignored bytes, then marker
        push_item(8'h80, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h12, 1'b1);
        push_item(8'h01, 1'b0);
        push_item(8'h00, 1'b1);
        // early end on the second byte, then on the third byte after a wrapped second byte
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h00, 1'b1);
        // early end inside the header
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hAA, 1'b0);
        push_item(8'h55, 1'b1);
        wait_for_drain();

        random_start = bytes_queued;
        queue_file(1'b1, 0);
        while (bytes_queued < random_start + RANDOM_ITEMS) begin
            if ($urandom_range(99) < 70) queue_file(1'b0, $urandom_range(0, 300));
            else queue_noise();
        end

        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && run_reports.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
